/* src/kdcd_pkg.sv */
// Shared types, constants and event codes for the key debounce click detector.
`timescale 1ns / 1ps
package kdcd_pkg;

   localparam int NUM_KEYS    = 4;
   localparam int KEY_W       = 2;
   localparam int TICK_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   localparam logic [1:0] DOUBLE_CLICK_COUNT = 2'd2;

   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_CLICK   = 3'd2,
      EV_DOUBLE  = 3'd3,
      EV_LONG    = 3'd4
   } event_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEBOUNCE_TICKS     = 3'd0,
      REG_LONG_PRESS_TICKS   = 3'd1,
      REG_CLICK_WINDOW_TICKS = 3'd2,
      REG_LONG_PRESS_WINDOW  = 3'd3,
      REG_PIN_LOW_PRESSED    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] long_press_ticks;
      logic [15:0] click_window_ticks;
      logic [7:0]  long_press_window;
      logic        pin_low_pressed;
   } cfg_type;

   typedef struct packed {
      logic              raw_released;
      logic [TICK_W-1:0] change_tick;
      logic              stable_pressed;
      logic [TICK_W-1:0] pressed_at_tick;
      logic [TICK_W-1:0] released_at_tick;
      logic [1:0]        short_clicks;
   } key_state_type;

   typedef struct packed {
      logic [1:0]     ev_count;
      event_code_type ev0;
      event_code_type ev1;
   } eval_result_type;

endpackage

/* src/kdcd_eval.sv */
// Per-sample evaluation: next key state and up to two events for one scan sample.
`timescale 1ns / 1ps
module kdcd_eval (
   input  kdcd_pkg::cfg_type         cfg,
   input  logic [kdcd_pkg::KEY_W-1:0]  key_index,
   input  logic                        pin_level,
   input  logic [kdcd_pkg::TICK_W-1:0] now_tick,
   input  kdcd_pkg::key_state_type    cur_state,
   output kdcd_pkg::key_state_type    next_state,
   output kdcd_pkg::eval_result_type  result
);
   import kdcd_pkg::*;

   logic              in_range;
   logic              raw;
   logic              raw_changed;
   logic [TICK_W-1:0] change_new;
   logic [TICK_W-1:0] since_change;
   logic              deb_ok;
   logic              want;
   logic              toggle;
   logic [TICK_W-1:0] held_rel;
   logic              is_long;
   logic              in_window;
   logic [1:0]        clicks_inc;
   logic [1:0]        clicks_new;
   logic              stable_new;
   logic [TICK_W-1:0] held_now;
   logic [TICK_W-1:0] held_over;
   logic              held_long;

   always_comb begin
      in_range     = {1'b0, key_index} < (KEY_W+1)'(NUM_KEYS);
      raw          = cfg.pin_low_pressed ? pin_level : ~pin_level;
      raw_changed  = raw != cur_state.raw_released;
      change_new   = raw_changed ? now_tick : cur_state.change_tick;
      since_change = raw_changed ? '0 : (now_tick - cur_state.change_tick);
      deb_ok       = since_change >= {16'd0, cfg.debounce_ticks};
      want         = ~raw;
      toggle       = deb_ok && (want != cur_state.stable_pressed);
      held_rel     = now_tick - cur_state.pressed_at_tick;
      is_long      = held_rel >= {16'd0, cfg.long_press_ticks};
      in_window    = (now_tick - cur_state.released_at_tick) < {16'd0, cfg.click_window_ticks};
      clicks_inc   = cur_state.short_clicks + 2'd1;

      next_state = cur_state;
      result     = '{ev_count: 2'd0, ev0: EV_PRESS, ev1: EV_PRESS};
      next_state.raw_released = raw;
      next_state.change_tick  = change_new;

      clicks_new = cur_state.short_clicks;
      if (toggle) begin
         next_state.stable_pressed = want;
         if (want) begin
            next_state.pressed_at_tick = now_tick;
            result.ev_count = 2'd1;
            result.ev0      = EV_PRESS;
         end else begin
            next_state.released_at_tick = now_tick;
            priority if (is_long) begin
               result.ev_count = 2'd2;
               result.ev0      = EV_LONG;
               result.ev1      = EV_RELEASE;
            end else if (in_window && clicks_inc == DOUBLE_CLICK_COUNT) begin
               clicks_new      = 2'd0;
               result.ev_count = 2'd2;
               result.ev0      = EV_DOUBLE;
               result.ev1      = EV_RELEASE;
            end else begin
               clicks_new      = in_window ? clicks_inc : 2'd1;
               result.ev0      = EV_RELEASE;
               result.ev1      = EV_CLICK;
               result.ev_count = (clicks_new == 2'd1) ? 2'd2 : 2'd1;
            end
         end
      end
      next_state.short_clicks = clicks_new;

      stable_new = next_state.stable_pressed;
      held_now   = (toggle && want) ? '0 : held_rel;
      held_over  = held_now - {16'd0, cfg.long_press_ticks};
      held_long  = (held_now >= {16'd0, cfg.long_press_ticks})
                   && (held_over < {24'd0, cfg.long_press_window});
      if (stable_new && held_long && result.ev_count != 2'd2) begin
         if (result.ev_count == 2'd0) begin
            result.ev0 = EV_LONG;
         end else begin
            result.ev1 = EV_LONG;
         end
         result.ev_count = result.ev_count + 2'd1;
      end

      if (!in_range) begin
         next_state      = cur_state;
         result.ev_count = 2'd0;
      end
   end

endmodule

/* src/key_debounce_click_detector_unit.sv */
// Top level of the key debounce and click detector.
//
// Scan samples enter on the req_ stream: key index, raw pin level and the
// current 32-bit tick count. Each sample yields zero, one or two events on the
// rsp_ stream (key number and event code); tlast marks the final event of a
// sample. Registers are written over the csr_ channel, which is always ready;
// write them only while the block is idle.
//
// An accepted sample is held in the input register, evaluated in one pass
// against the per-key state, and its events are loaded into the output
// register. Throughput: one sample per cycle while each yields at most one
// event and rsp_tready is high; a sample with two events holds the output
// register until both are sent; the drain of one event per cycle sets the rate.
//
// Reset clears all per-key state to released with zero timestamps and loads
// the register defaults. When the receiver stalls, the pending event holds
// and the input register fills, after which req_tready drops.
`timescale 1ns / 1ps
module key_debounce_click_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] key_index, [2] pin_level, [34:3] now_tick, [39:35] zero
   input  logic [kdcd_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] key_number, [4:2] event_code, [7:5] zero
   output logic [kdcd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kdcd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [kdcd_pkg::CSR_DATA_W-1:0]       csr_data
);
   import kdcd_pkg::*;

   cfg_type           cfg_ff;
   key_state_type     state_ff [NUM_KEYS];

   logic              in_valid_ff;
   logic [KEY_W-1:0]  in_key_ff;
   logic              in_pin_ff;
   logic [TICK_W-1:0] in_now_ff;

   logic [1:0]        out_cnt_ff;
   logic [KEY_W-1:0]  out_key_ff;
   event_code_type    out_ev0_ff;
   event_code_type    out_ev1_ff;

   key_state_type     next_state_in;
   eval_result_type   result;
   logic              advance;
   logic              rsp_accept;

   kdcd_eval u_eval (
      .cfg        (cfg_ff),
      .key_index  (in_key_ff),
      .pin_level  (in_pin_ff),
      .now_tick   (in_now_ff),
      .cur_state  (state_ff[in_key_ff]),
      .next_state (next_state_in),
      .result     (result)
   );

   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign advance    = in_valid_ff
                       && (out_cnt_ff == 2'd0 || (out_cnt_ff == 2'd1 && rsp_tready));
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_cnt_ff != 2'd0;
   assign rsp_tlast  = out_cnt_ff == 2'd1;
   assign rsp_tdata  = {3'd0, out_ev0_ff, out_key_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= 16'd20;
         cfg_ff.long_press_ticks   <= 16'd1000;
         cfg_ff.click_window_ticks <= 16'd300;
         cfg_ff.long_press_window  <= 8'd10;
         cfg_ff.pin_low_pressed    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEBOUNCE_TICKS:     cfg_ff.debounce_ticks     <= csr_data;
            REG_LONG_PRESS_TICKS:   cfg_ff.long_press_ticks   <= csr_data;
            REG_CLICK_WINDOW_TICKS: cfg_ff.click_window_ticks <= csr_data;
            REG_LONG_PRESS_WINDOW:  cfg_ff.long_press_window  <= csr_data[7:0];
            REG_PIN_LOW_PRESSED:    cfg_ff.pin_low_pressed    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            state_ff[i] <= '{raw_released: 1'b1, change_tick: '0, stable_pressed: 1'b0,
                             pressed_at_tick: '0, released_at_tick: '0, short_clicks: 2'd0};
         end
      end else if (advance) begin
         state_ff[in_key_ff] <= next_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_key_ff <= req_tdata[1:0];
         in_pin_ff <= req_tdata[2];
         in_now_ff <= req_tdata[34:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         priority if (advance && result.ev_count != 2'd0) begin
            out_cnt_ff <= result.ev_count;
         end else if (rsp_accept) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (advance && result.ev_count != 2'd0) begin
         out_key_ff <= in_key_ff;
         out_ev0_ff <= result.ev0;
         out_ev1_ff <= result.ev1;
      end else if (rsp_accept) begin
         out_ev0_ff <= out_ev1_ff;
      end
   end

endmodule

/* src/kdcd_checker.sv */
// Port-level checker for the key debounce click detector, bound to the top level.
`timescale 1ns / 1ps
module kdcd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [kdcd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);
   import kdcd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled transaction changed");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tvalid && rsp_tdata[1:0] == $past(rsp_tdata[1:0]))
      else $error("second event of a sample missing or for another key");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:2] <= 3'd4 && rsp_tdata[7:5] == 3'd0)
      else $error("bad event code");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind key_debounce_click_detector_unit kdcd_checker u_kdcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
